FILE: hw/rtl/gmma_pkg.sv
// Shared types and constants for the diagonal-covariance mixture M-step accumulator.
// Used by the controller, the datapath and the top level; depends on nothing else.
package gmma_pkg;

  localparam int CNT_W = 8;
  localparam int OP_W = 3;

  localparam logic [63:0] EPS_Q24 = 64'd20;

  localparam logic REQ_ACC = 1'b0;
  localparam logic REQ_FIN = 1'b1;

  localparam logic REG_NUM_CLUSTERS = 1'b0;
  localparam logic REG_VAR_BIAS = 1'b1;

  localparam logic [OP_W-1:0] OP_WEIGHT = 3'd0;

  // Division codes per dimension: mean first, then mean of squares.
  function automatic logic [OP_W-1:0] op_mean(input int d);
    op_mean = OP_W'(1 + 2 * d);
  endfunction

  function automatic logic [OP_W-1:0] op_ex2(input int d);
    op_ex2 = OP_W'(2 + 2 * d);
  endfunction

  typedef struct packed {
    logic            load;
    logic            mul;
    logic            sq;
    logic            acc_wr;
    logic            tot_clr;
    logic            tot_acc;
    logic            idx_zero;
    logic            idx_inc;
    logic            fin_load;
    logic            div_start;
    logic            div_store;
    logic [OP_W-1:0] div_op;
    logic            sq_mean;
    logic            emit;
    logic            clear_valid;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic kuse_zero;
    logic idx_last;
    logic div_done;
  } dp_sts_t;

endpackage

FILE: hw/rtl/gmm_diag_mstep_accumulator_top.sv
// Top level of the diagonal-covariance mixture M-step accumulator.
// Instantiates gmma_ctrl and gmma_dp; uses gmma_pkg.
//
// Usage: raise start with req_type and the item fields; the item is taken at a rising
// edge where start is high and busy is low. An accumulate item adds resp, resp*x and
// resp*x*x into the addressed cluster's saturating 64-bit sums; it holds busy through
// two multiplier stages and the write back (the RAM read is done at the accepting edge),
// so a new accumulate item can be taken only after the write back. An accumulate
// item whose cluster is not in use is taken and dropped with no busy time.
// A finalize item first walks the clusters in use to form the total (a read state and
// an accumulate state each), then per cluster runs 1 + 2*DIMS divisions through one
// shared 64-step divider, which ends at once when the quotient saturates, plus read,
// load, square and output states. Each result appears on the result ports for one
// cycle, flagged by out_valid, registered in the cycle after it is formed; last marks
// the final cluster. The receiver cannot stall. A finalize ends with a clear state that
// clears all accumulators at once through per-cluster valid bits.
// Reset (rst, synchronous) clears all accumulators, sets num_clusters to 16 and the
// variance regularizer to 17. Configuration writes (cfg_we, cfg_index, cfg_data) take
// effect at once and are meant only while busy is low.
module gmm_diag_mstep_accumulator_top #(
  parameter int MAX_CLUSTERS = 16,
  parameter int DIMS = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [3:0]         cluster,
  input  logic [24:0]        resp,
  input  logic signed [15:0] coord_a,
  input  logic signed [15:0] coord_b,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               out_valid,
  output logic [3:0]         out_cluster,
  output logic [16:0]        weight,
  output logic signed [23:0] mean_a,
  output logic signed [23:0] mean_b,
  output logic [39:0]        var_a,
  output logic [39:0]        var_b,
  output logic               last
);
  import gmma_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  gmma_ctrl #(.DIMS(DIMS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type), .busy(busy),
    .cmd(cmd), .sts(sts)
  );

  gmma_dp #(.MAX_CLUSTERS(MAX_CLUSTERS), .DIMS(DIMS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cluster(cluster), .resp(resp), .coord_a(coord_a), .coord_b(coord_b),
    .out_valid(out_valid), .out_cluster(out_cluster), .weight(weight),
    .mean_a(mean_a), .mean_b(mean_b), .var_a(var_a), .var_b(var_b), .last(last)
  );
endmodule

FILE: hw/rtl/gmma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the accumulator stores.
module gmma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/gmma_div.sv
// Iterative restoring divider: 128-bit dividend by 64-bit divisor, one quotient bit per cycle.
// Saturates to all ones when the quotient does not fit. Stand-alone.
module gmma_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] hi,
  input  logic [63:0] lo,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [63:0] rem;
  logic [63:0] dvd;
  logic [63:0] dsr;
  logic [5:0]  cnt;
  logic        running;
  logic [63:0] shifted;
  logic        take;

  always_comb begin
    shifted = {rem[62:0], dvd[63]};
    take = rem[63] || (shifted >= dsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == 64'd0 || hi >= den) begin
          quo <= '1;
          done <= 1'b1;
        end else begin
          rem <= hi;
          dvd <= lo;
          dsr <= den;
          quo <= '0;
          cnt <= '0;
          running <= 1'b1;
        end
      end else if (running) begin
        rem <= take ? shifted - dsr : shifted;
        quo <= {quo[62:0], take};
        dvd <= {dvd[62:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/gmma_dp.sv
// Datapath: configuration registers, accumulator RAMs with valid bits, multipliers,
// saturating adders, the shared divider and the result registers. Uses gmma_pkg,
// gmma_ram and gmma_div.
module gmma_dp #(
  parameter int MAX_CLUSTERS = 16,
  parameter int DIMS = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  gmma_pkg::dp_cmd_t   cmd,
  output gmma_pkg::dp_sts_t   sts,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic [3:0]          cluster,
  input  logic [24:0]         resp,
  input  logic signed [15:0]  coord_a,
  input  logic signed [15:0]  coord_b,
  output logic                out_valid,
  output logic [3:0]          out_cluster,
  output logic [16:0]         weight,
  output logic signed [23:0]  mean_a,
  output logic signed [23:0]  mean_b,
  output logic [39:0]         var_a,
  output logic [39:0]         var_b,
  output logic                last
);
  import gmma_pkg::*;

  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam logic [CNT_W-1:0] MAX_K = CNT_W'(MAX_CLUSTERS);

  logic [4:0]         num_clusters;
  logic [23:0]        var_bias;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   kuse;
  logic [CNT_W-1:0]   cl_ext;
  logic [24:0]        r_q;
  logic [MAX_CLUSTERS-1:0] valid;
  logic               hit;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [63:0]        rt_rd;
  logic [63:0]        rt_cur;
  logic [64:0]        rt_sum;
  logic [63:0]        rt_new;
  logic [64:0]        nk_sum;
  logic [63:0]        nk_cur;
  logic [64:0]        tot_sum;
  logic [63:0]        total;
  logic [63:0]        nk;
  logic [16:0]        w_q;
  logic [63:0]        div_hi;
  logic [63:0]        div_lo;
  logic [63:0]        div_den;
  logic               div_done;
  logic [63:0]        div_quo;

  logic [15:0]        mag_q   [DIMS];
  logic               xneg_q  [DIMS];
  logic [40:0]        p_q     [DIMS];
  logic [56:0]        sq_q    [DIMS];
  logic [63:0]        smag_q  [DIMS];
  logic               sneg_q  [DIMS];
  logic [63:0]        wss_q   [DIMS];
  logic [31:0]        hp_q    [DIMS];
  logic [63:0]        ex2_q   [DIMS];
  logic [39:0]        msq_q   [DIMS];
  logic signed [23:0] mean_q  [DIMS];
  logic [39:0]        var_q   [DIMS];

  assign cl_ext = CNT_W'(cluster);
  assign kuse = (CNT_W'(num_clusters) > MAX_K) ? MAX_K : CNT_W'(num_clusters);
  assign raddr = cmd.load ? cl_ext[AW-1:0] : idx[AW-1:0];
  assign waddr = idx[AW-1:0];
  assign hit = valid[idx[AW-1:0]];

  assign sts.in_range = cl_ext < kuse;
  assign sts.kuse_zero = (kuse == '0);
  assign sts.idx_last = ((idx + CNT_W'(1)) == kuse);
  assign sts.div_done = div_done;

  // A cluster row not written since the last clear reads as zero.
  always_comb begin
    rt_cur = hit ? rt_rd : 64'd0;
    rt_sum = {1'b0, rt_cur} + {40'd0, r_q};
    rt_new = rt_sum[64] ? '1 : rt_sum[63:0];
    nk_sum = {1'b0, rt_cur} + {1'b0, EPS_Q24};
    nk_cur = nk_sum[64] ? '1 : nk_sum[63:0];
    tot_sum = {1'b0, total} + {1'b0, nk_cur};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= 5'd16;
      var_bias <= 24'd17;
      valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_CLUSTERS: num_clusters <= cfg_data[4:0];
          default: var_bias <= cfg_data;
        endcase
      end
      if (cmd.clear_valid) begin
        valid <= '0;
      end else if (cmd.acc_wr) begin
        valid[idx[AW-1:0]] <= 1'b1;
      end
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= cl_ext;
      r_q <= resp;
    end else if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CNT_W'(1);
    end
    if (cmd.tot_clr) begin
      total <= '0;
    end else if (cmd.tot_acc) begin
      total <= tot_sum[64] ? '1 : tot_sum[63:0];
    end
    if (cmd.fin_load) begin
      nk <= nk_cur;
    end
    if (cmd.div_store && cmd.div_op == OP_WEIGHT) begin
      w_q <= (div_quo > 64'd65536) ? 17'd65536 : div_quo[16:0];
    end
    if (cmd.emit) begin
      out_cluster <= idx[3:0];
      weight <= w_q;
      last <= sts.idx_last;
    end
  end

  gmma_ram #(.WIDTH(64), .DEPTH(MAX_CLUSTERS)) u_rt_ram (
    .clk(clk), .we(cmd.acc_wr), .waddr(waddr), .wdata(rt_new),
    .raddr(raddr), .rdata(rt_rd)
  );

  always_comb begin
    div_hi = {48'd0, nk[63:48]};
    div_lo = {nk[47:0], 16'd0};
    div_den = total;
    for (int d = 0; d < DIMS; d++) begin
      if (cmd.div_op == op_mean(d)) begin
        div_hi = {48'd0, smag_q[d][63:48]};
        div_lo = {smag_q[d][47:0], 16'd0};
        div_den = nk;
      end else if (cmd.div_op == op_ex2(d)) begin
        div_hi = {56'd0, wss_q[d][63:56]};
        div_lo = {wss_q[d][55:0], 8'd0};
        div_den = nk;
      end
    end
  end

  gmma_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .hi(div_hi), .lo(div_lo),
    .den(div_den), .done(div_done), .quo(div_quo)
  );

  for (genvar g = 0; g < DIMS; g++) begin : g_dim
    logic signed [15:0] x;
    logic [63:0]        ws_rd;
    logic [63:0]        wss_rd;
    logic [63:0]        ws_cur;
    logic [63:0]        wss_cur;
    logic [63:0]        sp;
    logic [64:0]        ws_sum;
    logic [63:0]        ws_new;
    logic [64:0]        wss_sum;
    logic [63:0]        wss_new;
    logic [63:0]        hp_sq;
    logic [23:0]        mq;
    logic [23:0]        mq_neg;
    logic [63:0]        ex2r;
    logic [63:0]        var64;

    if (g == 0) begin : g_a
      assign x = coord_a;
    end else begin : g_b
      assign x = coord_b;
    end

    always_comb begin
      ws_cur = hit ? ws_rd : 64'd0;
      wss_cur = hit ? wss_rd : 64'd0;
      sp = xneg_q[g] ? (64'd0 - {23'd0, p_q[g]}) : {23'd0, p_q[g]};
      ws_sum = {ws_cur[63], ws_cur} + {sp[63], sp};
      // Signed overflow shows as the two top bits of the wide sum differing.
      if (ws_sum[64] != ws_sum[63]) begin
        ws_new = ws_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        ws_new = ws_sum[63:0];
      end
      wss_sum = {1'b0, wss_cur} + {8'd0, sq_q[g]};
      wss_new = wss_sum[64] ? '1 : wss_sum[63:0];
      hp_sq = {32'd0, hp_q[g]} * {32'd0, hp_q[g]};
      mq = hp_q[g][31:8];
      mq_neg = 24'd0 - ((mq > 24'h800000) ? 24'h800000 : mq);
      ex2r = ex2_q[g] + {40'd0, var_bias};
      var64 = (ex2r > {24'd0, msq_q[g]}) ? ex2r - {24'd0, msq_q[g]} : 64'd0;
    end

    gmma_ram #(.WIDTH(64), .DEPTH(MAX_CLUSTERS)) u_ws_ram (
      .clk(clk), .we(cmd.acc_wr), .waddr(waddr), .wdata(ws_new),
      .raddr(raddr), .rdata(ws_rd)
    );

    gmma_ram #(.WIDTH(64), .DEPTH(MAX_CLUSTERS)) u_wss_ram (
      .clk(clk), .we(cmd.acc_wr), .waddr(waddr), .wdata(wss_new),
      .raddr(raddr), .rdata(wss_rd)
    );

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        xneg_q[g] <= x[15];
        mag_q[g] <= x[15] ? 16'd0 - x : x;
      end
      if (cmd.mul) begin
        p_q[g] <= 41'(r_q * mag_q[g]);
      end
      if (cmd.sq) begin
        sq_q[g] <= 57'(p_q[g] * mag_q[g]);
      end
      if (cmd.fin_load) begin
        sneg_q[g] <= ws_cur[63];
        smag_q[g] <= ws_cur[63] ? 64'd0 - ws_cur : ws_cur;
        wss_q[g] <= wss_cur;
      end
      if (cmd.div_store && cmd.div_op == op_mean(g)) begin
        hp_q[g] <= (div_quo > 64'h80000000) ? 32'h80000000 : div_quo[31:0];
      end
      if (cmd.div_store && cmd.div_op == op_ex2(g)) begin
        ex2_q[g] <= (div_quo > 64'h8000000000000000) ? 64'h8000000000000000 : div_quo;
      end
      if (cmd.sq_mean) begin
        msq_q[g] <= hp_sq[63:24];
      end
      if (cmd.emit) begin
        if (sneg_q[g]) begin
          mean_q[g] <= mq_neg;
        end else begin
          mean_q[g] <= (mq > 24'h7FFFFF) ? 24'h7FFFFF : mq;
        end
        var_q[g] <= (var64 > 64'hFFFFFFFFFF) ? 40'hFFFFFFFFFF : var64[39:0];
      end
    end
  end

  assign mean_a = mean_q[0];
  assign var_a = var_q[0];
  if (DIMS > 1) begin : g_two
    assign mean_b = mean_q[DIMS-1];
    assign var_b = var_q[DIMS-1];
  end else begin : g_one
    assign mean_b = '0;
    assign var_b = '0;
  end
endmodule

FILE: hw/rtl/gmma_ctrl.sv
// Controller: sequences accumulate updates and the finalize walk over clusters.
// Uses gmma_pkg; drives the datapath only through command and status structs.
module gmma_ctrl #(
  parameter int DIMS = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              req_type,
  output logic              busy,
  output gmma_pkg::dp_cmd_t cmd,
  input  gmma_pkg::dp_sts_t sts
);
  import gmma_pkg::*;

  localparam logic [OP_W-1:0] LAST_OP = OP_W'(2 * DIMS);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC_MUL, S_ACC_SQ, S_ACC_WR, S_TOT_RD, S_TOT_ACC, S_FIN_RD,
    S_FIN_LOAD, S_DIV_GO, S_DIV_WAIT, S_FIN_SQ, S_FIN_OUT, S_FIN_CLR
  } state_t;

  state_t          state;
  logic [OP_W-1:0] op;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.div_op = op;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_ACC) begin
            cmd.load = sts.in_range;
          end else begin
            cmd.tot_clr = 1'b1;
            cmd.idx_zero = 1'b1;
          end
        end
      end
      S_ACC_MUL: cmd.mul = 1'b1;
      S_ACC_SQ: cmd.sq = 1'b1;
      S_ACC_WR: cmd.acc_wr = 1'b1;
      S_TOT_RD: ;
      S_TOT_ACC: begin
        cmd.tot_acc = 1'b1;
        cmd.idx_zero = sts.idx_last;
        cmd.idx_inc = !sts.idx_last;
      end
      S_FIN_RD: ;
      S_FIN_LOAD: cmd.fin_load = 1'b1;
      S_DIV_GO: cmd.div_start = 1'b1;
      S_DIV_WAIT: cmd.div_store = sts.div_done;
      S_FIN_SQ: cmd.sq_mean = 1'b1;
      S_FIN_OUT: begin
        cmd.emit = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      S_FIN_CLR: cmd.clear_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_WEIGHT;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (req_type == REQ_ACC) begin
              if (sts.in_range) begin
                state <= S_ACC_MUL;
              end
            end else if (sts.kuse_zero) begin
              state <= S_FIN_CLR;
            end else begin
              state <= S_TOT_RD;
            end
          end
        end
        S_ACC_MUL: state <= S_ACC_SQ;
        S_ACC_SQ: state <= S_ACC_WR;
        S_ACC_WR: state <= S_IDLE;
        S_TOT_RD: state <= S_TOT_ACC;
        S_TOT_ACC: state <= sts.idx_last ? S_FIN_RD : S_TOT_RD;
        S_FIN_RD: state <= S_FIN_LOAD;
        S_FIN_LOAD: begin
          op <= OP_WEIGHT;
          state <= S_DIV_GO;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            if (op == LAST_OP) begin
              state <= S_FIN_SQ;
            end else begin
              op <= op + OP_W'(1);
              state <= S_DIV_GO;
            end
          end
        end
        S_FIN_SQ: state <= S_FIN_OUT;
        S_FIN_OUT: state <= sts.idx_last ? S_FIN_CLR : S_FIN_RD;
        S_FIN_CLR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
